@@ sv/arqs_pkg.sv @@
// Package for the affinity ready queue scheduler.
// Field widths, command codes, chain operations and control structs.
// No dependencies.
package arqs_pkg;

	localparam int CMD_W         = 2;
	localparam int TASK_W        = 4;
	localparam int HART_W        = 3;
	localparam int AFF_W         = 8;
	localparam int COUNT_W       = 5;
	localparam int NUM_TASK_IDS  = 2 ** TASK_W;
	localparam int DEF_MAX_TASKS = 16;
	localparam int DEF_NUM_HARTS = 8;

	typedef enum logic [CMD_W-1:0] {
		CMD_ENQ     = 2'd0,
		CMD_SCHED   = 2'd1,
		CMD_REMOVE  = 2'd2,
		CMD_SET_AFF = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		OP_HOLD,
		OP_PUSH,
		OP_ROT,
		OP_DROP
	} chain_op_t;

	typedef struct packed {
		chain_op_t         op;
		logic [TASK_W-1:0] push_id;
		logic [TASK_W-1:0] head_id;
	} chain_ctl_t;

	typedef struct packed {
		logic              set_flag;
		logic [TASK_W-1:0] set_id;
		logic              clr_flag;
		logic [TASK_W-1:0] clr_id;
		logic              set_aff;
		logic [TASK_W-1:0] aff_id;
		logic [AFF_W-1:0]  aff_val;
	} tbl_wr_t;

endpackage

@@ sv/arqs_ifs.sv @@
// Handshake channels of the ready queue scheduler: command word in, result word out.
// Depends on arqs_pkg.
interface arq_in_if import arqs_pkg::*;;
	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  cmd;
	logic [TASK_W-1:0] task_req;
	logic [HART_W-1:0] hart;
	logic [AFF_W-1:0]  affinity;
	logic              requeue_current;

	modport source (output valid, cmd, task_req, hart, affinity, requeue_current, input ready);
	modport sink (input valid, cmd, task_req, hart, affinity, requeue_current, output ready);
endinterface

interface arq_out_if import arqs_pkg::*;;
	logic               valid;
	logic               ready;
	logic [TASK_W-1:0]  chosen_task;
	logic               found;
	logic [COUNT_W-1:0] queue_count;
	logic               refused;

	modport source (output valid, chosen_task, found, queue_count, refused, input ready);
	modport sink (input valid, chosen_task, found, queue_count, refused, output ready);
endinterface

@@ sv/arqs_cell.sv @@
// One slot of the FIFO chain: valid bit and task id, shifts toward the head.
// Depends on arqs_pkg.
module arqs_cell import arqs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  chain_ctl_t        ctl,
	input  logic              prev_valid,
	input  logic              next_valid,
	input  logic [TASK_W-1:0] next_id,
	output logic              valid,
	output logic [TASK_W-1:0] id
);

	logic              valid_q;
	logic [TASK_W-1:0] id_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			unique case (ctl.op)
				OP_PUSH: begin
					if (!valid_q && prev_valid) valid_q <= 1'b1;
				end
				OP_DROP: begin
					valid_q <= next_valid;
				end
				OP_HOLD, OP_ROT: ;
			endcase
		end
	end

	// rotate: the tail slot takes the old head
	always_ff @(posedge clk) begin
		unique case (ctl.op)
			OP_PUSH: begin
				if (!valid_q && prev_valid) id_q <= ctl.push_id;
			end
			OP_ROT: begin
				if (valid_q) id_q <= next_valid ? next_id : ctl.head_id;
			end
			OP_DROP: begin
				id_q <= next_id;
			end
			OP_HOLD: ;
		endcase
	end

	assign valid = valid_q;
	assign id    = id_q;

endmodule

@@ sv/arqs_tbl.sv @@
// Per-task queued flags and affinity masks.
// Depends on arqs_pkg.
module arqs_tbl import arqs_pkg::*; #(
	parameter int NUM_IDS = NUM_TASK_IDS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  tbl_wr_t           wr,
	input  logic [TASK_W-1:0] flag_rd_id,
	input  logic [TASK_W-1:0] aff_rd_id,
	output logic              flag_rd,
	output logic [AFF_W-1:0]  aff_rd
);

	localparam int              IW     = $clog2(NUM_IDS);
	localparam logic [TASK_W:0] ID_LIM = (TASK_W + 1)'(NUM_IDS);

	logic             flags_q [NUM_IDS];
	logic [AFF_W-1:0] aff_q   [NUM_IDS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int e = 0; e < NUM_IDS; e++) begin
				flags_q[e] <= 1'b0;
				aff_q[e]   <= '1;
			end
		end else begin
			for (int e = 0; e < NUM_IDS; e++) begin
				if (wr.set_flag && wr.set_id == TASK_W'(e)) begin
					flags_q[e] <= 1'b1;
				end else if (wr.clr_flag && wr.clr_id == TASK_W'(e)) begin
					flags_q[e] <= 1'b0;
				end
				if (wr.set_aff && wr.aff_id == TASK_W'(e)) aff_q[e] <= wr.aff_val;
			end
		end
	end

	assign flag_rd = ({1'b0, flag_rd_id} < ID_LIM) && flags_q[flag_rd_id[IW-1:0]];
	assign aff_rd  = ({1'b0, aff_rd_id} < ID_LIM) ? aff_q[aff_rd_id[IW-1:0]] : '0;

endmodule

@@ sv/affinity_ready_queue_scheduler_unit.sv @@
// Affinity ready queue scheduler: FIFO of task ids in a chain of shifting cells.
// Enqueue, set-mask and a remove of an unqueued task go straight from execute to done;
// schedule (valid hart, non-empty queue) and remove of a queued task first scan the
// chain, rotating it once around over the queue length after any requeue (at most
// MAX_TASKS). One word in flight. Result held in an output register.
// Reset: queue empty, all queued flags clear, all affinity masks all ones.
module affinity_ready_queue_scheduler_unit import arqs_pkg::*; #(
	parameter int MAX_TASKS = DEF_MAX_TASKS,
	parameter int NUM_HARTS = DEF_NUM_HARTS
) (
	input logic       clk,
	input logic       arst_n,
	arq_in_if.sink    req,
	arq_out_if.source rsp
);

	localparam int NUM_IDS = (MAX_TASKS < NUM_TASK_IDS) ? MAX_TASKS : NUM_TASK_IDS;
	localparam int LEN_W   = $clog2(MAX_TASKS + 1);

	typedef enum logic [1:0] {S_IDLE, S_EXEC, S_SCAN, S_DONE} state_t;

	state_t             state_q;
	cmd_t               cmd_q;
	logic [TASK_W-1:0]  task_q;
	logic [HART_W-1:0]  hart_q;
	logic [AFF_W-1:0]   aff_q;
	logic               requeue_q;
	logic [LEN_W-1:0]   len_q;
	logic [LEN_W-1:0]   steps_q;
	logic               dropped_q;
	logic [TASK_W-1:0]  chosen_q;
	logic               found_q;
	logic               refused_q;
	logic               rsp_valid_q;
	logic [TASK_W-1:0]  rsp_chosen_q;
	logic               rsp_found_q;
	logic [COUNT_W-1:0] rsp_count_q;
	logic               rsp_refused_q;

	logic [MAX_TASKS-1:0] cell_valid;
	logic [TASK_W-1:0]    cell_id [MAX_TASKS];
	chain_ctl_t           chain_ctl;
	tbl_wr_t              tbl_wr;
	logic                 flag_rd;
	logic [AFF_W-1:0]     aff_rd;
	logic                 task_ok;
	logic                 hart_ok;
	logic                 push_ok;
	logic                 do_push;
	logic                 match;
	logic [LEN_W-1:0]     len_after_push;

	assign task_ok        = int'(task_q) < MAX_TASKS;
	assign hart_ok        = int'(hart_q) < NUM_HARTS;
	assign push_ok        = task_ok && !flag_rd && (len_q != LEN_W'(MAX_TASKS));
	assign do_push        = (state_q == S_EXEC) && push_ok
		&& (cmd_q == CMD_ENQ || (cmd_q == CMD_SCHED && requeue_q));
	assign len_after_push = do_push ? len_q + LEN_W'(1) : len_q;
	assign match          = !dropped_q && cell_valid[0]
		&& ((cmd_q == CMD_SCHED) ? aff_rd[hart_q] : (cell_id[0] == task_q));

	always_comb begin
		chain_ctl.op      = OP_HOLD;
		chain_ctl.push_id = task_q;
		chain_ctl.head_id = cell_id[0];
		tbl_wr.set_flag   = do_push;
		tbl_wr.set_id     = task_q;
		tbl_wr.clr_flag   = 1'b0;
		tbl_wr.clr_id     = cell_id[0];
		tbl_wr.set_aff    = (state_q == S_EXEC) && (cmd_q == CMD_SET_AFF) && task_ok;
		tbl_wr.aff_id     = task_q;
		tbl_wr.aff_val    = aff_q;
		unique case (state_q)
			S_EXEC: begin
				if (do_push) chain_ctl.op = OP_PUSH;
			end
			S_SCAN: begin
				chain_ctl.op    = match ? OP_DROP : OP_ROT;
				tbl_wr.clr_flag = match;
			end
			S_IDLE, S_DONE: ;
		endcase
	end

	for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
		logic              prev_v;
		logic              nxt_v;
		logic [TASK_W-1:0] nxt_id;

		if (i == 0) begin : g_head
			assign prev_v = 1'b1;
		end else begin : g_body
			assign prev_v = cell_valid[i-1];
		end
		if (i == MAX_TASKS - 1) begin : g_last
			assign nxt_v  = 1'b0;
			assign nxt_id = '0;
		end else begin : g_link
			assign nxt_v  = cell_valid[i+1];
			assign nxt_id = cell_id[i+1];
		end

		arqs_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (chain_ctl),
			.prev_valid (prev_v),
			.next_valid (nxt_v),
			.next_id    (nxt_id),
			.valid      (cell_valid[i]),
			.id         (cell_id[i])
		);
	end

	arqs_tbl #(
		.NUM_IDS (NUM_IDS)
	) u_tbl (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr         (tbl_wr),
		.flag_rd_id (task_q),
		.aff_rd_id  (cell_id[0]),
		.flag_rd    (flag_rd),
		.aff_rd     (aff_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			len_q       <= '0;
			steps_q     <= '0;
			dropped_q   <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && rsp.ready && state_q != S_DONE) rsp_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						cmd_q     <= cmd_t'(req.cmd);
						task_q    <= req.task_req;
						hart_q    <= req.hart;
						aff_q     <= req.affinity;
						requeue_q <= req.requeue_current;
						chosen_q  <= '0;
						found_q   <= 1'b0;
						refused_q <= 1'b0;
						dropped_q <= 1'b0;
						state_q   <= S_EXEC;
					end
				end
				S_EXEC: begin
					len_q   <= len_after_push;
					state_q <= S_DONE;
					unique case (cmd_q)
						CMD_ENQ: begin
							if (!push_ok) refused_q <= 1'b1;
						end
						CMD_SCHED: begin
							if (requeue_q && !push_ok) refused_q <= 1'b1;
							if (hart_ok && len_after_push != '0) begin
								steps_q <= len_after_push;
								state_q <= S_SCAN;
							end
						end
						CMD_REMOVE: begin
							if (flag_rd) begin
								steps_q <= len_q;
								state_q <= S_SCAN;
							end
						end
						CMD_SET_AFF: ;
					endcase
				end
				S_SCAN: begin
					if (match) begin
						len_q     <= len_q - LEN_W'(1);
						dropped_q <= 1'b1;
						if (cmd_q == CMD_SCHED) begin
							chosen_q <= cell_id[0];
							found_q  <= 1'b1;
						end
					end
					steps_q <= steps_q - LEN_W'(1);
					if (steps_q == LEN_W'(1)) state_q <= S_DONE;
				end
				S_DONE: begin
					if (!rsp_valid_q || rsp.ready) begin
						rsp_valid_q   <= 1'b1;
						rsp_chosen_q  <= chosen_q;
						rsp_found_q   <= found_q;
						rsp_count_q   <= COUNT_W'(len_q);
						rsp_refused_q <= refused_q;
						state_q       <= S_IDLE;
					end
				end
			endcase
		end
	end

	assign req.ready       = (state_q == S_IDLE);
	assign rsp.valid       = rsp_valid_q;
	assign rsp.chosen_task = rsp_chosen_q;
	assign rsp.found       = rsp_found_q;
	assign rsp.queue_count = rsp_count_q;
	assign rsp.refused     = rsp_refused_q;

	// occupied slots always form a packed run from the head
	a_len_matches_cells: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(cell_valid) == int'(len_q))
		else $error("queue length differs from occupied slot count");

	a_cells_packed: assert property (@(posedge clk) disable iff (!arst_n)
		(cell_valid & (cell_valid + MAX_TASKS'(1))) == '0)
		else $error("hole in the slot chain");

	a_scan_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (steps_q != '0 && steps_q <= len_q + LEN_W'(dropped_q)))
		else $error("scan step count out of range");

	a_no_grant_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.found) |-> (rsp.chosen_task == '0))
		else $error("task reported without a grant");

endmodule

@@ tb/affinity_ready_queue_scheduler_unit_test.sv @@
// Self-checking bench for affinity_ready_queue_scheduler_unit: directed and random command
// words, each result word predicted in-line from a behavioral copy of the ready queue.
// Depends on arqs_pkg, arq_in_if and arq_out_if.
module affinity_ready_queue_scheduler_unit_test;
	timeunit 1ns;
	timeprecision 1ps;
	import arqs_pkg::*;

	localparam int PERIOD       = 20;
	localparam int MAX          = DEF_MAX_TASKS;
	localparam int HARTS        = DEF_NUM_HARTS;
	localparam int RANDOM_WORDS = 1230;
	localparam int CALM_TAIL    = 150;
	localparam int STALL_LIMIT  = 4000;
	localparam int DRAIN_CYCLES = 40;

	typedef struct packed {
		cmd_t              op;
		logic [TASK_W-1:0] task_id;
		logic [HART_W-1:0] hart;
		logic [AFF_W-1:0]  mask;
		logic              requeue;
		logic              hold;
	} cmd_word_t;

	typedef struct packed {
		logic [TASK_W-1:0]  chosen;
		logic               found;
		logic [COUNT_W-1:0] count;
		logic               refused;
	} grant_t;

	logic clk;
	logic arst_n;

	arq_in_if  req_ch ();
	arq_out_if rsp_ch ();

	affinity_ready_queue_scheduler_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	cmd_word_t cmd_backlog[$];
	grant_t    expected_grants[$];
	cmd_word_t on_wire;
	bit        word_up;
	int        gap_left;
	int        stall_left;
	int        idle_odds;
	int        errors;
	int        idle_cycles;
	int        words_in;

	logic [TASK_W-1:0] fifo_ids[MAX];
	int                fifo_len;
	bit                queued[MAX];
	logic [AFF_W-1:0]  mask_of[MAX];

	initial clk = 1'b0;
	always #(PERIOD / 2) clk = ~clk;

	task automatic report_error(string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		errors++;
	endtask

	function automatic bit push_id(logic [TASK_W-1:0] t);
		if (t >= MAX || queued[t] || fifo_len >= MAX)
			return 1'b0;
		fifo_ids[fifo_len] = t;
		fifo_len++;
		queued[t] = 1'b1;
		return 1'b1;
	endfunction

	function automatic void drop_slot(int p);
		logic [TASK_W-1:0] t;
		t = fifo_ids[p];
		for (int i = p; i + 1 < fifo_len; i++)
			fifo_ids[i] = fifo_ids[i + 1];
		fifo_len--;
		if (t < MAX)
			queued[t] = 1'b0;
	endfunction

	function automatic grant_t apply_command(cmd_word_t w);
		grant_t r;
		logic [TASK_W-1:0] t;
		r = '0;
		case (w.op)
			CMD_ENQ: begin
				r.refused = !push_id(w.task_id);
			end
			CMD_SCHED: begin
				if (w.requeue && !push_id(w.task_id))
					r.refused = 1'b1;
				if (w.hart < HARTS) begin
					for (int p = 0; p < fifo_len; p++) begin
						t = fifo_ids[p];
						if (t < MAX && mask_of[t][w.hart]) begin
							r.chosen = t;
							r.found  = 1'b1;
							drop_slot(p);
							break;
						end
					end
				end
			end
			CMD_REMOVE: begin
				if (w.task_id < MAX && queued[w.task_id]) begin
					for (int p = 0; p < fifo_len; p++) begin
						if (fifo_ids[p] == w.task_id) begin
							drop_slot(p);
							break;
						end
					end
				end
			end
			default: begin
				if (w.task_id < MAX)
					mask_of[w.task_id] = w.mask;
			end
		endcase
		r.count = COUNT_W'(fifo_len);
		return r;
	endfunction

	function automatic void enqueue_word(cmd_t op, int id, int h, int m, bit rq, bit hold);
		cmd_word_t w;
		w.op      = op;
		w.task_id = TASK_W'(id);
		w.hart    = HART_W'(h);
		w.mask    = AFF_W'(m);
		w.requeue = rq;
		w.hold    = hold;
		cmd_backlog.push_back(w);
	endfunction

	// bias 0 fills the queue, 1 drains it, anything else is a mix weighted toward schedule
	function automatic cmd_word_t random_word(int bias);
		cmd_word_t w;
		int roll;
		int enq_pct;
		int sched_pct;
		int rem_pct;
		case (bias)
			0:       begin enq_pct = 60; sched_pct = 20; rem_pct = 10; end
			1:       begin enq_pct = 15; sched_pct = 50; rem_pct = 25; end
			default: begin enq_pct = 30; sched_pct = 40; rem_pct = 15; end
		endcase
		w.task_id = TASK_W'($urandom_range(0, NUM_TASK_IDS - 1));
		w.hart    = HART_W'($urandom);
		w.requeue = 1'($urandom);
		w.hold    = 1'b0;
		case ($urandom_range(0, 3))
			0:       w.mask = '0;
			1:       w.mask = '1;
			2:       w.mask = AFF_W'(1) << $urandom_range(0, AFF_W - 1);
			default: w.mask = AFF_W'($urandom);
		endcase
		roll = $urandom_range(0, 99);
		if (roll < enq_pct)
			w.op = CMD_ENQ;
		else if (roll < enq_pct + sched_pct)
			w.op = CMD_SCHED;
		else if (roll < enq_pct + sched_pct + rem_pct)
			w.op = CMD_REMOVE;
		else
			w.op = CMD_SET_AFF;
		return w;
	endfunction

	initial begin
		int bias;
		cmd_word_t w;
		arst_n                 = 1'b0;
		req_ch.valid           = 1'b0;
		req_ch.cmd             = CMD_ENQ;
		req_ch.task_req        = '0;
		req_ch.hart            = '0;
		req_ch.affinity        = '0;
		req_ch.requeue_current = 1'b0;
		rsp_ch.ready           = 1'b0;
		on_wire                = '0;
		for (int i = 0; i < MAX; i++) begin
			fifo_ids[i] = '0;
			queued[i]   = 1'b0;
			mask_of[i]  = '1;
		end
		fifo_len = 0;
		bias     = 2;

		enqueue_word(CMD_SCHED, 0, 0, 8'h00, 0, 0);
		enqueue_word(CMD_ENQ, 0, 7, 8'hff, 1, 0);
		enqueue_word(CMD_ENQ, 15, 0, 8'h00, 0, 0);
		enqueue_word(CMD_ENQ, 0, 0, 8'h00, 0, 0);
		enqueue_word(CMD_REMOVE, 7, 0, 8'h00, 0, 0);
		enqueue_word(CMD_SET_AFF, 0, 0, 8'h00, 0, 0);
		enqueue_word(CMD_SET_AFF, 15, 0, 8'h80, 0, 0);
		enqueue_word(CMD_SCHED, 1, 0, 8'h00, 0, 0);
		enqueue_word(CMD_SCHED, 15, 7, 8'h00, 1, 0);
		enqueue_word(CMD_SCHED, 3, 7, 8'h00, 1, 0);
		enqueue_word(CMD_SET_AFF, 0, 0, 8'hff, 0, 0);
		enqueue_word(CMD_ENQ, 9, 0, 8'h00, 0, 0);
		enqueue_word(CMD_ENQ, 4, 0, 8'h00, 0, 0);
		enqueue_word(CMD_ENQ, 10, 0, 8'h00, 0, 0);
		enqueue_word(CMD_REMOVE, 9, 0, 8'h00, 0, 0);
		enqueue_word(CMD_REMOVE, 10, 0, 8'h00, 0, 0);
		enqueue_word(CMD_SET_AFF, 4, 0, 8'h01, 0, 0);
		enqueue_word(CMD_SCHED, 12, 5, 8'h00, 1, 1);
		enqueue_word(CMD_SCHED, 0, 2, 8'h00, 0, 0);
		enqueue_word(CMD_REMOVE, 4, 0, 8'h00, 0, 0);
		enqueue_word(CMD_SCHED, 6, 4, 8'h00, 1, 0);
		enqueue_word(CMD_SET_AFF, 6, 0, 8'h55, 0, 0);

		for (int n = 0; n < RANDOM_WORDS; n++) begin
			if (n % 40 == 0)
				bias = $urandom_range(0, 2);
			w = random_word(bias);
			if (n % 300 == 0)
				w.hold = 1'b1;
			cmd_backlog.push_back(w);
		end

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (cmd_backlog.size() != 0 || word_up || expected_grants.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("affinity_ready_queue_scheduler_unit_test: clean");
		else
			$display("affinity_ready_queue_scheduler_unit_test: errors");
		$finish;
	end

	// driver: a held word waits until the queue model has no result word outstanding
	always @(negedge clk) begin
		if (arst_n) begin
			if (!word_up) begin
				if (gap_left > 0)
					gap_left--;
				else if (cmd_backlog.size() != 0 &&
					!(cmd_backlog[0].hold && expected_grants.size() != 0)) begin
					on_wire = cmd_backlog.pop_front();
					word_up = 1'b1;
				end
			end
			req_ch.valid           <= word_up;
			req_ch.cmd             <= on_wire.op;
			req_ch.task_req        <= on_wire.task_id;
			req_ch.hart            <= on_wire.hart;
			req_ch.affinity        <= on_wire.mask;
			req_ch.requeue_current <= on_wire.requeue;
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (stall_left > 0) begin
				stall_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
				if (cmd_backlog.size() >= CALM_TAIL && $urandom_range(0, 29) < idle_odds)
					stall_left = $urandom_range(1, 19);
			end
		end
	end

	always @(posedge clk) begin : monitor
		grant_t want;
		if (arst_n) begin
			idle_cycles++;
			if (req_ch.valid && req_ch.ready) begin
				expected_grants.push_back(apply_command(on_wire));
				word_up     = 1'b0;
				idle_cycles = 0;
				words_in++;
				if (words_in % 100 == 0)
					idle_odds = $urandom_range(0, 2);
				if (cmd_backlog.size() >= CALM_TAIL && $urandom_range(0, 9) < 2 * idle_odds)
					gap_left = $urandom_range(1, 19);
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				idle_cycles = 0;
				if (expected_grants.size() == 0) begin
					report_error($sformatf("result word with none expected: task %0d found %0b",
						rsp_ch.chosen_task, rsp_ch.found));
				end else begin
					want = expected_grants.pop_front();
					if (rsp_ch.chosen_task !== want.chosen)
						report_error($sformatf("chosen_task %0d, expected %0d",
							rsp_ch.chosen_task, want.chosen));
					if (rsp_ch.found !== want.found)
						report_error($sformatf("found %0b, expected %0b",
							rsp_ch.found, want.found));
					if (rsp_ch.queue_count !== want.count)
						report_error($sformatf("queue_count %0d, expected %0d",
							rsp_ch.queue_count, want.count));
					if (rsp_ch.refused !== want.refused)
						report_error($sformatf("refused %0b, expected %0b",
							rsp_ch.refused, want.refused));
				end
			end
			if (idle_cycles >= STALL_LIMIT) begin
				$display("affinity_ready_queue_scheduler_unit_test: errors");
				$finish;
			end
		end
	end

endmodule
